// File: rtl/ssbc_pkg.sv
// Package for the spread sketch bitmap counter: shared constants, state codes
// and the constant log2 helper used at elaboration. No dependencies.
package ssbc_pkg;

    // Configuration port
    localparam int CFG_W  = 9;
    localparam int CFG_AW = 2;
    localparam logic [CFG_AW-1:0] CFG_COLS_FIRST  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_COLS_SECOND = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_COLS_THIRD  = 2'd2;
    localparam logic [CFG_W-1:0]  CFG_RST_FIRST   = 9'd256;
    localparam logic [CFG_W-1:0]  CFG_RST_SECOND  = 9'd255;
    localparam logic [CFG_W-1:0]  CFG_RST_THIRD   = 9'd253;

    // Word layout
    localparam int KEY_W       = 32;
    localparam int HASH_W      = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int EST_W       = 12;
    localparam int ZCNT_W      = 10;
    localparam int OUT_TDATA_W = 24;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Table count and index of the last table
    localparam int NTABLE = 3;
    localparam logic [1:0] TBL_LAST = 2'd2;

    // Zero counting: one chunk per cycle, split in byte groups
    localparam int CHUNK_W = 64;
    localparam int GROUP_W = 8;
    localparam int NGROUP  = CHUNK_W / GROUP_W;

    // Fixed point log / ln constants
    localparam int FRAC_W = 31;
    localparam logic [31:0] LN2_Q28 = 32'd186065279;
    localparam int SPLIT_W = 18;
    localparam int S_SHIFT = 27;
    localparam int E_SHIFT = 32;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_RMW,
        S_CNT,
        S_NORM,
        S_LOG,
        S_DSUB,
        S_D_LO,
        S_D_HI,
        S_S_SUM,
        S_E_LO,
        S_E_HI,
        S_DONE
    } t_state;

    // log2(x) in unsigned Q.31, x >= 1; used for constants only
    function automatic logic [63:0] log2_q31(input int unsigned x);
        int unsigned k;
        logic [63:0] m;
        logic [63:0] res;
        k = 0;
        for (int i = 0; i < 31; i++) begin
            if ((x >> (i + 1)) != 0) begin
                k = i + 1;
            end
        end
        m   = (64'(x) << 31) >> k;
        res = 64'(k) << 31;
        for (int i = 30; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd2 << 31)) begin
                m      = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/spread_sketch_bitmap_counter.sv
// Top level of the spread sketch bitmap counter: sequencer, modulo lanes,
// zero counter and log estimator. Uses ssbc_pkg and ssbc_ram.
//
// Each word carries a command: record sets one bit in the flow's column of each of the
// three tables, query ANDs the three columns and returns the zero count and the
// linear-counting estimate BITS*ln(BITS/z). One word is in flight at a time.
// A record passes through the bit-serial key modulo lanes (key mod each column count,
// side by side, with hash mod BITS_PER_COLUMN taken by a reciprocal multiply on the
// shared multiplier, a back-multiply and one correction step) and then a read and a
// write per table for the read-modify-write on the single RAM port. A query runs the
// modulo lanes, three row reads, one 64-bit chunk of zero counting per cycle, log2
// squaring on the shared 32x32 multiplier, one fraction bit per square, and the
// multiplies for ln and the final scale. After reset the block clears all of the
// 3*COLS_PER_TABLE bitmap RAM rows (768 at defaults) one row per cycle, and takes no
// word until that is done; configuration writes are taken at all times.
module spread_sketch_bitmap_counter #(
    parameter int COLS_PER_TABLE  = 256,
    parameter int BITS_PER_COLUMN = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [ssbc_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [ssbc_pkg::CFG_W-1:0]        i_cfg_data,
    // input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ssbc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // flow_key[31:0], bit_hash[63:32]
    input  logic                              s_axis_tuser,  // cmd
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ssbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // spread_estimate[11:0],
                                                             // zero_bit_count[21:12]
);

    import ssbc_pkg::*;

    localparam int CW     = $clog2(COLS_PER_TABLE + 1);
    localparam int BW     = $clog2(BITS_PER_COLUMN + 1);
    localparam int DEPTH  = NTABLE * COLS_PER_TABLE;
    localparam int AW     = $clog2(DEPTH);
    localparam int NCH    = (BITS_PER_COLUMN + CHUNK_W - 1) / CHUNK_W;
    localparam int SHW    = NCH * CHUNK_W;
    localparam int KW     = $clog2(BW);
    localparam int DW     = FRAC_W + KW;
    localparam int SW     = DW + 1;
    localparam int CNT_W  = ($clog2(NCH) > 5) ? $clog2(NCH) : 5;
    localparam logic [DW-1:0] L_BITS = DW'(log2_q31(BITS_PER_COLUMN));
    // floor(2^32 / BITS): quotient estimate is low by at most one
    localparam logic [31:0] HASH_RECIP = 32'((64'd1 << 32) / BITS_PER_COLUMN);

    // zeros in one chunk: byte counts, then their sum
    function automatic logic [6:0] count_zeros(input logic [CHUNK_W-1:0] c);
        logic [3:0] part;
        logic [6:0] tot;
        tot = '0;
        for (int g = 0; g < NGROUP; g++) begin
            part = '0;
            for (int j = 0; j < GROUP_W; j++) begin
                part = part + 4'(!c[g*GROUP_W+j]);
            end
            tot = tot + 7'(part);
        end
        return tot;
    endfunction

    // state and control
    t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_tbl, n_tbl;
    logic             r_ovalid, n_ovalid;
    logic [CFG_W-1:0] r_cfg [NTABLE];

    // payload
    logic                r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [CW-1:0]       r_rem [NTABLE];
    logic [CW-1:0]       n_rem [NTABLE];
    logic [BW-1:0]       r_hrem, n_hrem;
    logic [SHW-1:0]      r_sh, n_sh;
    logic [BW-1:0]       r_zeros, n_zeros;
    logic [KW-1:0]       r_k, n_k;
    logic [31:0]         r_m, n_m;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [DW-1:0]       r_d, n_d;
    logic [63:0]         r_plo, n_plo;
    logic [63:0]         r_phi, n_phi;
    logic [SW-1:0]       r_s, n_s;
    logic [EST_W-1:0]    r_est, n_est;
    logic [ZCNT_W-1:0]   r_zcnt, n_zcnt;

    // RAM port
    logic [AW-1:0]              ram_addr;
    logic                       ram_we;
    logic [BITS_PER_COLUMN-1:0] ram_wdata;
    logic [BITS_PER_COLUMN-1:0] ram_rdata;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    // helpers
    logic [CW-1:0]              eff [NTABLE];
    logic [AW-1:0]              row_sel;
    logic [BITS_PER_COLUMN-1:0] bit_mask;
    logic [SHW-1:0]             rd_pad;
    logic [CW:0]                trial;
    logic [BW-1:0]              zuse;
    logic [KW-1:0]              norm_k;
    logic [32:0]                sq;
    logic [65:0]                sum_p;
    logic [33:0]                est_full;

    assign prod = mul_a * mul_b;

    // effective column counts: zero acts as one, clamp to table size
    always_comb begin
        for (int t = 0; t < NTABLE; t++) begin
            if (r_cfg[t] == '0) begin
                eff[t] = CW'(1);
            end else if (32'(r_cfg[t]) > COLS_PER_TABLE) begin
                eff[t] = CW'(COLS_PER_TABLE);
            end else begin
                eff[t] = CW'(r_cfg[t]);
            end
        end
    end

    assign row_sel  = AW'(r_rem[r_tbl]) + AW'(32'(r_tbl) * COLS_PER_TABLE);
    assign bit_mask = {{(BITS_PER_COLUMN-1){1'b0}}, 1'b1} << r_hrem;
    assign rd_pad   = ~(SHW'(~ram_rdata));
    assign sum_p    = (66'(r_phi) << SPLIT_W) + 66'(r_plo);
    assign sq       = prod[63:31];
    assign zuse     = (r_zeros == '0) ? BW'(1) : r_zeros;

    // leading one of the zero count
    always_comb begin
        norm_k = '0;
        for (int i = 0; i < BW; i++) begin
            if (zuse[i]) begin
                norm_k = KW'(i);
            end
        end
    end

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cnt    = r_cnt;
        n_tbl    = r_tbl;
        n_ovalid = r_ovalid;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_hash   = r_hash;
        n_rem    = r_rem;
        n_hrem   = r_hrem;
        n_sh     = r_sh;
        n_zeros  = r_zeros;
        n_k      = r_k;
        n_m      = r_m;
        n_frac   = r_frac;
        n_d      = r_d;
        n_plo    = r_plo;
        n_phi    = r_phi;
        n_s      = r_s;
        n_est    = r_est;
        n_zcnt   = r_zcnt;

        s_axis_tready = 1'b0;
        ram_addr  = row_sel;
        ram_we    = 1'b0;
        ram_wdata = ram_rdata | bit_mask;
        mul_a     = r_m;
        mul_b     = r_m;
        trial     = '0;
        est_full  = '0;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_addr  = r_clr;
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_cmd  = s_axis_tuser;
                    n_key  = s_axis_tdata[KEY_W-1:0];
                    n_hash = s_axis_tdata[KEY_W+HASH_W-1:KEY_W];
                    for (int t = 0; t < NTABLE; t++) begin
                        n_rem[t] = '0;
                    end
                    n_hrem  = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            // one quotient bit per cycle in every key lane; bit index by
            // reciprocal multiply, back-multiply and one correction step
            S_DIV: begin
                for (int t = 0; t < NTABLE; t++) begin
                    trial = {r_rem[t], r_key[KEY_W-1]};
                    if (trial >= {1'b0, eff[t]}) begin
                        n_rem[t] = CW'(trial - {1'b0, eff[t]});
                    end else begin
                        n_rem[t] = CW'(trial);
                    end
                end
                if (r_cnt == CNT_W'(0)) begin
                    mul_a = r_hash;
                    mul_b = HASH_RECIP;
                    n_plo = prod;
                end else if (r_cnt == CNT_W'(1)) begin
                    n_hash = r_hash - r_plo[63:32] * 32'(BITS_PER_COLUMN);
                end else if (r_cnt == CNT_W'(2)) begin
                    if (r_hash >= 32'(BITS_PER_COLUMN)) begin
                        n_hrem = BW'(r_hash - 32'(BITS_PER_COLUMN));
                    end else begin
                        n_hrem = BW'(r_hash);
                    end
                end
                n_key  = r_key << 1;
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    n_tbl   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_RMW;
            end
            // row data valid: set the bit, or fold into the AND
            S_RMW: begin
                if (r_cmd == CMD_RECORD) begin
                    ram_we = 1'b1;
                end else if (r_tbl == '0) begin
                    n_sh = rd_pad;
                end else begin
                    n_sh = r_sh & rd_pad;
                end
                if (r_tbl == TBL_LAST) begin
                    n_cnt   = '0;
                    n_zeros = '0;
                    n_state = (r_cmd == CMD_QUERY) ? S_CNT : S_IDLE;
                end else begin
                    n_tbl   = r_tbl + 2'd1;
                    n_state = S_RD;
                end
            end
            S_CNT: begin
                n_zeros = r_zeros + BW'(count_zeros(r_sh[CHUNK_W-1:0]));
                n_sh    = r_sh >> CHUNK_W;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NCH - 1)) begin
                    n_state = S_NORM;
                end
            end
            // mantissa in Q1.31
            S_NORM: begin
                n_k     = norm_k;
                n_m     = 32'(zuse) << (5'd31 - 5'(norm_k));
                n_frac  = '0;
                n_cnt   = '0;
                n_state = S_LOG;
            end
            // one fraction bit per square
            S_LOG: begin
                if (sq[32]) begin
                    n_m    = sq[32:1];
                    n_frac = {r_frac[FRAC_W-2:0], 1'b1};
                end else begin
                    n_m    = sq[31:0];
                    n_frac = {r_frac[FRAC_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_W - 1)) begin
                    n_state = S_DSUB;
                end
            end
            S_DSUB: begin
                n_d     = L_BITS - {r_k, r_frac};
                n_state = S_D_LO;
            end
            S_D_LO: begin
                mul_a   = 32'(r_d[SPLIT_W-1:0]);
                mul_b   = LN2_Q28;
                n_plo   = prod;
                n_state = S_D_HI;
            end
            S_D_HI: begin
                mul_a   = 32'(r_d[DW-1:SPLIT_W]);
                mul_b   = LN2_Q28;
                n_phi   = prod;
                n_state = S_S_SUM;
            end
            S_S_SUM: begin
                n_s     = SW'(sum_p >> S_SHIFT);
                n_state = S_E_LO;
            end
            S_E_LO: begin
                mul_a   = 32'(r_s[SPLIT_W-1:0]);
                mul_b   = 32'(BITS_PER_COLUMN);
                n_plo   = prod;
                n_state = S_E_HI;
            end
            S_E_HI: begin
                mul_a   = 32'(r_s[SW-1:SPLIT_W]);
                mul_b   = 32'(BITS_PER_COLUMN);
                n_phi   = prod;
                n_state = S_DONE;
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                est_full = 34'(sum_p >> E_SHIFT);
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_est    = (est_full > 34'd4095) ? 12'd4095 : est_full[EST_W-1:0];
                    n_zcnt   = (32'(r_zeros) > 32'd1023) ? 10'd1023 : 10'(r_zeros);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_tbl    <= '0;
            r_ovalid <= 1'b0;
            r_cfg[0] <= CFG_RST_FIRST;
            r_cfg[1] <= CFG_RST_SECOND;
            r_cfg[2] <= CFG_RST_THIRD;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            r_tbl    <= n_tbl;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_COLS_FIRST:  r_cfg[0] <= i_cfg_data;
                    CFG_COLS_SECOND: r_cfg[1] <= i_cfg_data;
                    CFG_COLS_THIRD:  r_cfg[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_hash  <= n_hash;
        r_rem   <= n_rem;
        r_hrem  <= n_hrem;
        r_sh    <= n_sh;
        r_zeros <= n_zeros;
        r_k     <= n_k;
        r_m     <= n_m;
        r_frac  <= n_frac;
        r_d     <= n_d;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_s     <= n_s;
        r_est   <= n_est;
        r_zcnt  <= n_zcnt;
    end

    ssbc_ram #(
        .WIDTH(BITS_PER_COLUMN),
        .DEPTH(DEPTH)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_addr (ram_addr),
        .i_we   (ram_we),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-EST_W-ZCNT_W){1'b0}}, r_zcnt, r_est};

    // bit index lane has settled below the column width before any row access
    a_bit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD |-> r_hrem < BW'(BITS_PER_COLUMN))
        else $error("bit index out of column");

    // zero count can never pass the column width
    a_zero_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NORM |-> 32'(r_zeros) <= BITS_PER_COLUMN)
        else $error("zero count above column width");

    // a result only appears at the end of a query
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_DONE) && ($past(r_cmd) == CMD_QUERY))
        else $error("result word without query");

endmodule

// File: rtl/ssbc_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ssbc_ram #(
    parameter int WIDTH = 512,
    parameter int DEPTH = 768
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read of the same address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
